@@ rtl/core/mbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared codes and types of the multibyte character codec: status codes,
// encoding selector codes, register indexes and the result word layout.
// ----------------------------------------------------------------------------
package mbc_pkg;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [1:0] ST_ERROR      = 2'd2;

	localparam logic [2:0] ENC_UNIBYTE = 3'd0;
	localparam logic [2:0] ENC_UTF8    = 3'd1;
	localparam logic [2:0] ENC_EUCJP   = 3'd2;
	localparam logic [2:0] ENC_EUCCN   = 3'd3;
	localparam logic [2:0] ENC_SJIS    = 3'd4;

	localparam logic REG_ENC_SEL = 1'b0;
	localparam logic REG_STRICT  = 1'b1;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] EUC_SS2   = 8'h8E;
	localparam logic [7:0] EUC_SS3   = 8'h8F;

	localparam logic [23:0] UNI_MAX     = 24'h0000FF;
	localparam logic [23:0] UTF8_MAX1   = 24'h00007F;
	localparam logic [23:0] UTF8_MAX2   = 24'h0007FF;
	localparam logic [23:0] BMP_MAX     = 24'h00FFFF;
	localparam logic [23:0] UTF8_MAX4   = 24'h10FFFF;
	localparam logic [23:0] EUCJP_MAX3  = 24'h8FFFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  char_length;
		logic [23:0] code;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
	} mbc_result_t;

endpackage

@@ rtl/core/multibyte_char_codec_unit.sv @@
// ----------------------------------------------------------------------------
// multibyte_char_codec_unit
// Decodes the first character of a byte window or encodes one code value
// in the encoding chosen by a configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries op, the four window
//   bytes, bytes_available and code_in. A word is taken at a clock edge
//   with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) carries status, char_length,
//   code_out and out_byte0..3, one response word per request word.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes encoding_select (index 0) and strict_check (index 1); cfg_ready
//   is always high, writes are meant for when no word is in flight.
//   Path: a request word that is taken is held in the input register, and its
//   result is held in the result register, which drives the response outputs.
//   Throughput: one word per cycle while no response is held under rsp_stall,
//   set by the input register and the result register with the range compares and byte packing between them.
//   With a response held under rsp_stall, one more word fills the input
//   register, which then holds it with req_stall high; nothing is dropped.
//   Reset: both stages empty, encoding_select 0 (unibyte), strict_check 1.
// ----------------------------------------------------------------------------
module multibyte_char_codec_unit
	import mbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [7:0]  in_byte0,
	input  logic [7:0]  in_byte1,
	input  logic [7:0]  in_byte2,
	input  logic [7:0]  in_byte3,
	input  logic [2:0]  bytes_available,
	input  logic [23:0] code_in,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [2:0]  char_length,
	output logic [23:0] code_out,
	output logic [7:0]  out_byte0,
	output logic [7:0]  out_byte1,
	output logic [7:0]  out_byte2,
	output logic [7:0]  out_byte3,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);

	function automatic logic gr94(input logic [7:0] c);
		return c inside {[8'hA1:8'hFE]};
	endfunction

	function automatic logic gr96(input logic [7:0] c);
		return c inside {[8'hA0:8'hFF]};
	endfunction

	function automatic logic sj_lead(input logic [7:0] c);
		return c inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
	endfunction

	function automatic logic sj_trail(input logic [7:0] c);
		return (c inside {[8'h40:8'hFC]}) && (c != ASCII_MAX);
	endfunction

	function automatic logic utf8_trail(input logic [7:0] c);
		return c[7:6] == 2'b10;
	endfunction

	function automatic mbc_result_t decode_word(
		input logic [7:0] b0,
		input logic [7:0] b1,
		input logic [7:0] b2,
		input logic [7:0] b3,
		input logic [2:0] size,
		input logic [2:0] sel,
		input logic       strict
	);
		mbc_result_t r;
		logic [2:0]  n;
		logic        done;
		r    = '0;
		n    = 3'd1;
		done = 1'b0;
		if (size == 3'd0) begin
			done = 1'b1;
		end else if (sel == ENC_UTF8) begin
			if (b0 <= ASCII_MAX) begin
				n = 3'd1;
			end else if (b0[7:5] == 3'b110) begin
				n = 3'd2;
			end else if (b0[7:4] == 4'b1110) begin
				n = 3'd3;
			end else if (b0[7:3] == 5'b11110) begin
				n = 3'd4;
			end else begin
				r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
			end
			if (!done && strict && n >= 3'd2) begin
				if (size < 3'd2) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (!utf8_trail(b1)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end
			end
			if (!done && strict && n >= 3'd3) begin
				if (size < 3'd3) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (!utf8_trail(b2)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end
			end
			if (!done && strict && n == 3'd4) begin
				if (size < 3'd4) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (!utf8_trail(b3)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end
			end
			if (!done && !strict && size < n) begin
				r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
			end
			if (!done) begin
				case (n)
					3'd1:    r.code = {16'd0, b0};
					3'd2:    r.code = {13'd0, b0[4:0], b1[5:0]};
					3'd3:    r.code = {8'd0, b0[3:0], b1[5:0], b2[5:0]};
					default: r.code = {3'd0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
				endcase
				r.char_length = n;
				done = 1'b1;
			end
		end else if (sel == ENC_EUCJP) begin
			if (b0 <= ASCII_MAX) begin
				n = 3'd1;
			end else if (gr94(b0) || b0 == EUC_SS2) begin
				if (size < 3'd2) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (strict && !gr96(b1)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end else begin
					n = 3'd2;
				end
			end else if (b0 == EUC_SS3) begin
				if (strict) begin
					if (size < 3'd2) begin
						r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
					end else if (b1 == 8'hA0 || b1 == 8'hFF) begin
						n = 3'd2;
					end else if (!gr94(b1)) begin
						r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
					end else if (size < 3'd3) begin
						r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
					end else if (!gr94(b2)) begin
						r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
					end else begin
						n = 3'd3;
					end
				end else if (size < 3'd3) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else begin
					n = 3'd3;
				end
			end else begin
				r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
			end
		end else if (sel == ENC_EUCCN) begin
			if (b0 <= ASCII_MAX) begin
				n = 3'd1;
			end else if (gr94(b0)) begin
				if (size < 3'd2) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (strict && !gr96(b1)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end else begin
					n = 3'd2;
				end
			end else begin
				r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
			end
		end else if (sel == ENC_SJIS) begin
			if (sj_lead(b0)) begin
				if (size < 3'd2) begin
					r.status = ST_INCOMPLETE; r.char_length = size; done = 1'b1;
				end else if (strict && !sj_trail(b1)) begin
					r.status = ST_ERROR; r.char_length = 3'd1; done = 1'b1;
				end else begin
					n = 3'd2;
				end
			end
		end
		if (!done) begin
			case (n)
				3'd1:    r.code = {16'd0, b0};
				3'd2:    r.code = {8'd0, b0, b1};
				default: r.code = {b0, b1, b2};
			endcase
			r.char_length = n;
		end
		return r;
	endfunction

	function automatic mbc_result_t encode_word(
		input logic [23:0] ch,
		input logic [2:0]  sel,
		input logic        strict
	);
		mbc_result_t r;
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [7:0]  top;
		logic        bad;
		r   = '0;
		hi  = ch[15:8];
		lo  = ch[7:0];
		top = ch[23:16];
		bad = 1'b0;
		case (sel)
			ENC_UTF8: begin
				if (ch <= UTF8_MAX1) begin
					r.byte0 = lo; r.char_length = 3'd1;
				end else if (ch <= UTF8_MAX2) begin
					r.byte0 = {3'b110, ch[10:6]};
					r.byte1 = {2'b10, ch[5:0]};
					r.char_length = 3'd2;
				end else if (ch <= BMP_MAX) begin
					r.byte0 = {4'b1110, ch[15:12]};
					r.byte1 = {2'b10, ch[11:6]};
					r.byte2 = {2'b10, ch[5:0]};
					r.char_length = 3'd3;
				end else if (ch <= UTF8_MAX4) begin
					r.byte0 = {5'b11110, ch[20:18]};
					r.byte1 = {2'b10, ch[17:12]};
					r.byte2 = {2'b10, ch[11:6]};
					r.byte3 = {2'b10, ch[5:0]};
					r.char_length = 3'd4;
				end else begin
					bad = 1'b1;
				end
			end
			ENC_EUCJP: begin
				if (ch <= UTF8_MAX1) begin
					r.byte0 = lo; r.char_length = 3'd1;
				end else if (ch <= BMP_MAX) begin
					if (strict && ((!gr94(hi) && hi != EUC_SS2) || !gr96(lo))) begin
						bad = 1'b1;
					end else begin
						r.byte0 = hi; r.byte1 = lo; r.char_length = 3'd2;
					end
				end else if (ch <= EUCJP_MAX3) begin
					if (strict && (top != EUC_SS3 || !gr94(hi) || !gr94(lo))) begin
						bad = 1'b1;
					end else begin
						r.byte0 = top; r.byte1 = hi; r.byte2 = lo; r.char_length = 3'd3;
					end
				end else begin
					bad = 1'b1;
				end
			end
			ENC_EUCCN: begin
				if (ch <= UTF8_MAX1) begin
					r.byte0 = lo; r.char_length = 3'd1;
				end else if (ch <= BMP_MAX) begin
					if (strict && (!gr94(hi) || !gr96(lo))) begin
						bad = 1'b1;
					end else begin
						r.byte0 = hi; r.byte1 = lo; r.char_length = 3'd2;
					end
				end else begin
					bad = 1'b1;
				end
			end
			ENC_SJIS: begin
				if (strict && top != 8'd0) begin
					bad = 1'b1;
				end else if (sj_lead(hi)) begin
					if (strict && !sj_trail(lo)) begin
						bad = 1'b1;
					end else begin
						r.byte0 = hi; r.byte1 = lo; r.char_length = 3'd2;
					end
				end else begin
					r.byte0 = lo; r.char_length = 3'd1;
				end
			end
			default: begin
				if (strict && ch > UNI_MAX) begin
					bad = 1'b1;
				end else begin
					r.byte0 = lo; r.char_length = 3'd1;
				end
			end
		endcase
		if (bad) begin
			r = '0;
			r.status = ST_ERROR;
		end
		return r;
	endfunction

	logic [2:0]  enc_sel_q;
	logic        strict_q;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  b0_s1;
	logic [7:0]  b1_s1;
	logic [7:0]  b2_s1;
	logic [7:0]  b3_s1;
	logic [2:0]  size_s1;
	logic [23:0] code_s1;

	logic        valid_s2;
	mbc_result_t res_s2;

	mbc_result_t res;
	logic [2:0]  size_sat;
	logic        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_sel_q <= ENC_UNIBYTE;
			strict_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENC_SEL: enc_sel_q <= cfg_data;
				REG_STRICT:  strict_q  <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// response slot empty or being taken
	assign advance   = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1   <= op;
			b0_s1   <= in_byte0;
			b1_s1   <= in_byte1;
			b2_s1   <= in_byte2;
			b3_s1   <= in_byte3;
			size_s1 <= bytes_available;
			code_s1 <= code_in;
		end
	end

	assign size_sat = (size_s1 > 3'd4) ? 3'd4 : size_s1;

	always_comb begin
		if (op_s1) begin
			res = encode_word(code_s1, enc_sel_q, strict_q);
		end else begin
			res = decode_word(b0_s1, b1_s1, b2_s1, b3_s1, size_sat, enc_sel_q, strict_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp_valid   = valid_s2;
	assign status      = res_s2.status;
	assign char_length = res_s2.char_length;
	assign code_out    = res_s2.code;
	assign out_byte0   = res_s2.byte0;
	assign out_byte1   = res_s2.byte1;
	assign out_byte2   = res_s2.byte2;
	assign out_byte3   = res_s2.byte3;

endmodule

@@ verif/multibyte_char_codec_unit_tb.sv @@
// ----------------------------------------------------------------------------
// multibyte_char_codec_unit_tb
// Self-checking bench for the multibyte character codec. Directed words hit
// the range edges of every encoding, strict, and relaxed for UTF-8 and Shift-JIS. Random phases then
// sweep the encoding and strict settings with mostly well-formed characters.
// Both handshakes idle at random. Every response word is compared with a
// prediction made when its request word was taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multibyte_char_codec_unit_tb;
	import mbc_pkg::*;

	localparam int   STALL_LIMIT = 5000;
	localparam int   REPORT_MAX  = 10;
	localparam logic OP_DECODE   = 1'b0;
	localparam logic OP_ENCODE   = 1'b1;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        req_valid       = 1'b0;
	logic        req_stall;
	logic        op              = OP_DECODE;
	logic [7:0]  in_byte0        = '0;
	logic [7:0]  in_byte1        = '0;
	logic [7:0]  in_byte2        = '0;
	logic [7:0]  in_byte3        = '0;
	logic [2:0]  bytes_available = '0;
	logic [23:0] code_in         = '0;
	logic        rsp_valid;
	logic        rsp_stall       = 1'b0;
	logic [1:0]  status;
	logic [2:0]  char_length;
	logic [23:0] code_out;
	logic [7:0]  out_byte0;
	logic [7:0]  out_byte1;
	logic [7:0]  out_byte2;
	logic [7:0]  out_byte3;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic        cfg_index       = REG_ENC_SEL;
	logic [2:0]  cfg_data        = '0;

	logic [2:0]  cur_enc    = ENC_UNIBYTE;
	logic        cur_strict = 1'b1;
	int          gap_pct    = 32;

	mbc_result_t pending_results[$];
	int          mismatches    = 0;
	int          words_checked = 0;
	int          decodes_sent  = 0;
	int          encodes_sent  = 0;
	int          settings_used = 0;
	int          quiet_cycles  = 0;

	multibyte_char_codec_unit uut (.*);

	always #5 clk = ~clk;

	function automatic bit in_gr94(logic [7:0] c);
		return c >= 8'hA1 && c <= 8'hFE;
	endfunction

	function automatic bit in_gr96(logic [7:0] c);
		return c >= 8'hA0;
	endfunction

	function automatic bit sj_lead(logic [7:0] c);
		return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
	endfunction

	function automatic bit sj_trail(logic [7:0] c);
		return c >= 8'h40 && c <= 8'hFC && c != ASCII_MAX;
	endfunction

	function automatic mbc_result_t decode_error();
		mbc_result_t r;
		r = '0;
		r.status = ST_ERROR;
		r.char_length = 3'd1;
		return r;
	endfunction

	function automatic mbc_result_t decode_short(logic [2:0] size);
		mbc_result_t r;
		r = '0;
		r.status = ST_INCOMPLETE;
		r.char_length = size;
		return r;
	endfunction

	function automatic mbc_result_t predict_result(logic o, logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3, logic [2:0] avail, logic [23:0] cv);
		mbc_result_t r;
		logic [7:0]  w [4];
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [7:0]  top;
		logic [2:0]  size;
		int          n;
		bit          bad;
		r = '0;
		w[0] = b0;
		w[1] = b1;
		w[2] = b2;
		w[3] = b3;
		size = (avail > 3'd4) ? 3'd4 : avail;
		hi = cv[15:8];
		lo = cv[7:0];
		top = cv[23:16];
		n = 1;
		bad = 1'b0;
		if (o == OP_DECODE) begin
			if (size == 3'd0)
				return r;
			case (cur_enc)
			ENC_UTF8: begin
				if (w[0] <= ASCII_MAX) n = 1;
				else if (w[0][7:5] == 3'b110) n = 2;
				else if (w[0][7:4] == 4'b1110) n = 3;
				else if (w[0][7:3] == 5'b11110) n = 4;
				else return decode_error();
				if (cur_strict) begin
					for (int i = 1; i < n; i++) begin
						if (int'(size) <= i) return decode_short(size);
						if (w[i][7:6] != 2'b10) return decode_error();
					end
				end else if (int'(size) < n) begin
					return decode_short(size);
				end
				case (n)
				1: r.code = {16'h0, w[0]};
				2: r.code = {13'h0, w[0][4:0], w[1][5:0]};
				3: r.code = {8'h0, w[0][3:0], w[1][5:0], w[2][5:0]};
				default: r.code = {3'h0, w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
				endcase
				r.char_length = 3'(n);
				return r;
			end
			ENC_EUCJP: begin
				if (w[0] <= ASCII_MAX) begin
					n = 1;
				end else if (in_gr94(w[0]) || w[0] == EUC_SS2) begin
					if (size < 3'd2) return decode_short(size);
					if (cur_strict && !in_gr96(w[1])) return decode_error();
					n = 2;
				end else if (w[0] == EUC_SS3) begin
					if (cur_strict) begin
						if (size < 3'd2) return decode_short(size);
						if (w[1] == 8'hA0 || w[1] == 8'hFF) begin
							n = 2;
						end else begin
							if (!in_gr94(w[1])) return decode_error();
							if (size < 3'd3) return decode_short(size);
							if (!in_gr94(w[2])) return decode_error();
							n = 3;
						end
					end else begin
						if (size < 3'd3) return decode_short(size);
						n = 3;
					end
				end else begin
					return decode_error();
				end
			end
			ENC_EUCCN: begin
				if (w[0] <= ASCII_MAX) begin
					n = 1;
				end else if (in_gr94(w[0])) begin
					if (size < 3'd2) return decode_short(size);
					if (cur_strict && !in_gr96(w[1])) return decode_error();
					n = 2;
				end else begin
					return decode_error();
				end
			end
			ENC_SJIS: begin
				if (sj_lead(w[0])) begin
					if (size < 3'd2) return decode_short(size);
					if (cur_strict && !sj_trail(w[1])) return decode_error();
					n = 2;
				end
			end
			default: n = 1;
			endcase
			for (int i = 0; i < n; i++)
				r.code = {r.code[15:0], w[i]};
			r.char_length = 3'(n);
			return r;
		end
		n = 0;
		case (cur_enc)
		ENC_UTF8: begin
			if (cv <= UTF8_MAX1) begin
				r.byte0 = lo;
				n = 1;
			end else if (cv <= UTF8_MAX2) begin
				r.byte0 = {3'b110, cv[10:6]};
				r.byte1 = {2'b10, cv[5:0]};
				n = 2;
			end else if (cv <= BMP_MAX) begin
				r.byte0 = {4'b1110, cv[15:12]};
				r.byte1 = {2'b10, cv[11:6]};
				r.byte2 = {2'b10, cv[5:0]};
				n = 3;
			end else if (cv <= UTF8_MAX4) begin
				r.byte0 = {5'b11110, cv[20:18]};
				r.byte1 = {2'b10, cv[17:12]};
				r.byte2 = {2'b10, cv[11:6]};
				r.byte3 = {2'b10, cv[5:0]};
				n = 4;
			end else begin
				bad = 1'b1;
			end
		end
		ENC_EUCJP: begin
			if (cv <= {16'h0, ASCII_MAX}) begin
				r.byte0 = lo;
				n = 1;
			end else if (cv <= BMP_MAX) begin
				if (cur_strict && ((!in_gr94(hi) && hi != EUC_SS2) || !in_gr96(lo))) begin
					bad = 1'b1;
				end else begin
					r.byte0 = hi;
					r.byte1 = lo;
					n = 2;
				end
			end else if (cv <= EUCJP_MAX3) begin
				if (cur_strict && (top != EUC_SS3 || !in_gr94(hi) || !in_gr94(lo))) begin
					bad = 1'b1;
				end else begin
					r.byte0 = top;
					r.byte1 = hi;
					r.byte2 = lo;
					n = 3;
				end
			end else begin
				bad = 1'b1;
			end
		end
		ENC_EUCCN: begin
			if (cv <= {16'h0, ASCII_MAX}) begin
				r.byte0 = lo;
				n = 1;
			end else if (cv <= BMP_MAX) begin
				if (cur_strict && (!in_gr94(hi) || !in_gr96(lo))) begin
					bad = 1'b1;
				end else begin
					r.byte0 = hi;
					r.byte1 = lo;
					n = 2;
				end
			end else begin
				bad = 1'b1;
			end
		end
		ENC_SJIS: begin
			if (cur_strict && top != 8'h00) begin
				bad = 1'b1;
			end else if (sj_lead(hi)) begin
				if (cur_strict && !sj_trail(lo)) begin
					bad = 1'b1;
				end else begin
					r.byte0 = hi;
					r.byte1 = lo;
					n = 2;
				end
			end else begin
				r.byte0 = lo;
				n = 1;
			end
		end
		default: begin
			if (cur_strict && cv > UNI_MAX) begin
				bad = 1'b1;
			end else begin
				r.byte0 = lo;
				n = 1;
			end
		end
		endcase
		if (bad) begin
			r = '0;
			r.status = ST_ERROR;
		end else begin
			r.char_length = 3'(n);
		end
		return r;
	endfunction

	task automatic send_word(input logic o, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] avail,
			input logic [23:0] cv);
		while (int'($urandom_range(99)) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		in_byte0 <= b0;
		in_byte1 <= b1;
		in_byte2 <= b2;
		in_byte3 <= b3;
		bytes_available <= avail;
		code_in <= cv;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(predict_result(o, b0, b1, b2, b3, avail, cv));
		if (o == OP_ENCODE)
			encodes_sent++;
		else
			decodes_sent++;
	endtask

	task automatic send_decode(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] avail);
		send_word(OP_DECODE, b0, b1, b2, b3, avail, 24'h0);
	endtask

	task automatic send_encode(input logic [23:0] cv);
		send_word(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, cv);
	endtask

	// register writes only with nothing in flight
	task automatic write_setting(input logic idx, input logic [2:0] data);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ENC_SEL) begin
			cur_enc = data;
			settings_used++;
		end else begin
			cur_strict = data[0];
		end
		@(posedge clk);
	endtask

	task automatic send_random_word();
		logic [7:0]  w [4];
		logic [23:0] cv;
		logic [2:0]  avail;
		int          n;
		int          kind;
		for (int i = 0; i < 4; i++)
			w[i] = 8'($urandom);
		n = 1;
		kind = int'($urandom_range(99));
		// well-formed character at the head of the window, bar the random Shift-JIS single-byte case
		case (cur_enc)
		ENC_UTF8: begin
			n = int'($urandom_range(4, 1));
			for (int i = 1; i < n; i++)
				w[i][7:6] = 2'b10;
			case (n)
			1: w[0][7] = 1'b0;
			2: w[0][7:5] = 3'b110;
			3: w[0][7:4] = 4'b1110;
			default: w[0][7:3] = 5'b11110;
			endcase
		end
		ENC_EUCJP: begin
			case ($urandom_range(4))
			0: w[0][7] = 1'b0;
			1: begin
				w[0] = 8'($urandom_range(8'hFE, 8'hA1));
				w[1] = 8'($urandom_range(8'hFF, 8'hA0));
				n = 2;
			end
			2: begin
				w[0] = EUC_SS2;
				w[1] = 8'($urandom_range(8'hFF, 8'hA0));
				n = 2;
			end
			3: begin
				w[0] = EUC_SS3;
				w[1] = 8'($urandom_range(8'hFE, 8'hA1));
				w[2] = 8'($urandom_range(8'hFE, 8'hA1));
				n = 3;
			end
			default: begin
				w[0] = EUC_SS3;
				w[1] = $urandom_range(1) ? 8'hFF : 8'hA0;
				n = 2;
			end
			endcase
		end
		ENC_EUCCN: begin
			if ($urandom_range(3) == 0) begin
				w[0][7] = 1'b0;
			end else begin
				w[0] = 8'($urandom_range(8'hFE, 8'hA1));
				w[1] = 8'($urandom_range(8'hFF, 8'hA0));
				n = 2;
			end
		end
		ENC_SJIS: begin
			if ($urandom_range(3) != 0) begin
				w[0] = $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
					: 8'($urandom_range(8'hFC, 8'hE0));
				w[1] = 8'($urandom_range(8'hFC, 8'h40));
				if (w[1] == ASCII_MAX)
					w[1] = 8'h80;
				n = 2;
			end
		end
		default: n = 1;
		endcase
		cv = '0;
		for (int i = 0; i < n; i++)
			cv = {cv[15:0], w[i]};
		if (cur_enc == ENC_UTF8) begin
			case ($urandom_range(3))
			0: cv = 24'($urandom_range(UTF8_MAX1));
			1: cv = 24'($urandom_range(UTF8_MAX2, UTF8_MAX1 + 1));
			2: cv = 24'($urandom_range(BMP_MAX, UTF8_MAX2 + 1));
			default: cv = 24'($urandom_range(UTF8_MAX4, BMP_MAX + 1));
			endcase
		end
		// noise and broken sequences
		if (kind < 15) begin
			for (int i = 0; i < 4; i++)
				w[i] = 8'($urandom);
			cv = 24'($urandom);
		end else if (kind < 30) begin
			w[$urandom_range(3)] = 8'($urandom);
		end
		avail = ($urandom_range(99) < 65) ? 3'd4 : 3'($urandom_range(7));
		send_word($urandom_range(1) ? OP_ENCODE : OP_DECODE, w[0], w[1], w[2], w[3], avail, cv);
	endtask

	task automatic test_reset_state();
		send_decode(8'h41, 8'h42, 8'h43, 8'h44, 3'd0);
		send_decode(8'hFF, 8'h00, 8'h00, 8'h00, 3'd4);
		send_encode(24'h000100);
	endtask

	task automatic test_utf8();
		write_setting(REG_ENC_SEL, ENC_UTF8);
		write_setting(REG_STRICT, 3'd1);
		send_decode(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
		send_decode(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2);
		send_decode(8'hC3, 8'h41, 8'h00, 8'h00, 3'd4);
		send_decode(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4);
		send_encode(UTF8_MAX2);
		send_encode(UTF8_MAX4);
		send_encode(UTF8_MAX4 + 1);
		write_setting(REG_STRICT, 3'd0);
		send_decode(8'hE2, 8'h41, 8'h41, 8'h00, 3'd4);
	endtask

	task automatic test_eucjp();
		write_setting(REG_ENC_SEL, ENC_EUCJP);
		write_setting(REG_STRICT, 3'd1);
		send_decode(EUC_SS3, 8'hA0, 8'h00, 8'h00, 3'd4);
		send_decode(EUC_SS3, 8'hA1, 8'hFE, 8'h00, 3'd3);
		send_decode(EUC_SS2, 8'h20, 8'h00, 8'h00, 3'd4);
		send_encode(24'h8FA0A1);
	endtask

	task automatic test_euccn();
		write_setting(REG_ENC_SEL, ENC_EUCCN);
		send_decode(8'hB0, 8'hA1, 8'hFF, 8'hFF, 3'd7);
		send_encode(24'h00B0A1);
	endtask

	task automatic test_sjis();
		write_setting(REG_ENC_SEL, ENC_SJIS);
		send_decode(8'h81, 8'h7F, 8'h00, 8'h00, 3'd4);
		send_decode(8'hA0, 8'h81, 8'h40, 8'h00, 3'd4);
		send_encode(24'h00817F);
		send_encode(24'h008140);
		write_setting(REG_STRICT, 3'd0);
		send_encode(24'h12817F);
	endtask

	task automatic test_spare_selector();
		write_setting(REG_ENC_SEL, 3'(ENC_SJIS + 3));
		write_setting(REG_STRICT, 3'd1);
		send_decode(8'h8F, 8'hA1, 8'hA1, 8'h00, 3'd5);
		send_encode(24'h0001FF);
	endtask

	task automatic test_random_settings();
		logic [2:0] enc;
		logic       strict;
		for (int p = 0; p < 14; p++) begin
			if (p < 10) begin
				enc = 3'(p / 2);
				strict = (p % 2 == 0);
			end else if (p < 12) begin
				enc = 3'($urandom_range(7, ENC_SJIS + 1));
				strict = 1'($urandom_range(1));
			end else begin
				enc = 3'($urandom_range(ENC_SJIS));
				strict = 1'($urandom_range(1));
			end
			gap_pct = (p == 6 || p == 7) ? 0 : 32;
			write_setting(REG_ENC_SEL, enc);
			write_setting(REG_STRICT, {2'b00, strict});
			repeat ((gap_pct == 0) ? 80 : 40)
				send_random_word();
		end
		gap_pct = 32;
	endtask

	always @(posedge clk) begin
		rsp_stall <= (int'($urandom_range(99)) < gap_pct);
	end

	always @(posedge clk) begin
		mbc_result_t seen;
		mbc_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = {status, char_length, code_out, out_byte0, out_byte1, out_byte2, out_byte3};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected response word: st=%0d len=%0d code=%06h",
						seen.status, seen.char_length, seen.code);
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch: expected st=%0d len=%0d code=%06h bytes=%02h %02h %02h %02h",
							want.status, want.char_length, want.code, want.byte0, want.byte1,
							want.byte2, want.byte3);
						$display("          got      st=%0d len=%0d code=%06h bytes=%02h %02h %02h %02h",
							seen.status, seen.char_length, seen.code, seen.byte0, seen.byte1,
							seen.byte2, seen.byte3);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_utf8();
		test_eucjp();
		test_euccn();
		test_sjis();
		test_spare_selector();
		test_random_settings();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("covered %0d decode and %0d encode words across %0d encoding selections",
			decodes_sent, encodes_sent, settings_used);
		$display("%0d response words compared, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
